// ----- src/bdq_pkg.sv -----
// shared types and constants for the bounded deque with eviction
package bdq_pkg;

   localparam int DEF_MAX_ENTRIES = 16;
   localparam int DEF_DATA_WIDTH  = 32;

   localparam int OP_WIDTH       = 2;
   localparam int VALUE_WIDTH    = 32;
   localparam int POSITION_WIDTH = 4;
   localparam int STATUS_WIDTH   = 2;
   localparam int COUNT_WIDTH    = 5;
   localparam int LIMIT_WIDTH    = 5;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_PUSH_BACK  = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_REMOVE     = 2'd2
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_EVICT_FRONT = 2'd1,
      STATUS_EVICT_BACK  = 2'd2,
      STATUS_BAD_REMOVE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_EVICT_RD,
      S_REMOVE_RD,
      S_SHIFT,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0]       op;
      logic [VALUE_WIDTH-1:0]    value;
      logic [POSITION_WIDTH-1:0] position;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] removed_value;
      status_type             status;
      logic [COUNT_WIDTH-1:0] entry_count;
   } rsp_payload_type;

endpackage

// ----- src/bdq_stream_if.sv -----
// valid/ready channel carrying one payload per transaction
interface bdq_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, input ready, output payload);
   modport sink   (input valid, output ready, input payload);
endinterface

// ----- src/bounded_deque_with_eviction_top.sv -----
// bounded deque with eviction: circular store in a synchronous ram, pointer and count
// sequence: accept in S_IDLE, decide in S_EXEC, then a push with eviction passes S_EVICT_RD, a remove
//   passes S_REMOVE_RD and S_SHIFT for each later word, before the result is sent from S_RESULT
// throughput: one transaction at a time; the gap-closing shift after a remove moves one
//   word per cycle through the single ram read and write port
// reset: front pointer and count cleared, limit set to MAX_ENTRIES, no transaction pending;
//   the ram content is not cleared and needs no clearing pass
module bounded_deque_with_eviction_top #(
   parameter int MAX_ENTRIES = bdq_pkg::DEF_MAX_ENTRIES,
   parameter int DATA_WIDTH  = bdq_pkg::DEF_DATA_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   bdq_stream_if.sink                    req_bus,
   bdq_stream_if.source                  rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [bdq_pkg::LIMIT_WIDTH-1:0] csr_wr_data
);
   import bdq_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SW = AW + 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int LW = (CW > LIMIT_WIDTH) ? CW : LIMIT_WIDTH;

   // circular index: base plus offset, wrapped once at the store depth
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] s;
      s = SW'(base) + SW'(off);
      if (s >= SW'(MAX_ENTRIES)) begin
         s = s - SW'(MAX_ENTRIES);
      end
      return AW'(s);
   endfunction

   logic [DATA_WIDTH-1:0] store_mem [MAX_ENTRIES];
   logic [DATA_WIDTH-1:0] mem_rdata_ff;
   logic                  mem_we;
   logic                  mem_re;
   logic [AW-1:0]         mem_waddr;
   logic [AW-1:0]         mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata;

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] front_ff, front_in;
   logic [LW-1:0] limit_ff, limit_in;
   logic [CW-1:0] idx_ff, idx_in;

   logic [OP_WIDTH-1:0]       op_ff, op_in;
   logic [DATA_WIDTH-1:0]     word_ff, word_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;

   logic [DATA_WIDTH-1:0] res_value_ff, res_value_in;
   status_type            res_status_ff, res_status_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic          req_accept;
   logic          rsp_free;
   logic          full;
   logic          remove_ok;
   logic          more_after_rd;
   logic          more_after_shift;
   logic [CW:0]   idx_plus1;
   logic [CW:0]   idx_plus2;
   logic [AW-1:0] slot_count;
   logic [AW-1:0] slot_last;
   logic [AW-1:0] slot_pos;
   logic [AW-1:0] slot_idx;
   logic [AW-1:0] slot_idx1;
   logic [AW-1:0] slot_idx2;
   logic [AW-1:0] front_dec;
   logic [AW-1:0] front_inc;
   logic [LW-1:0] limit_clamp;

   assign req_accept = req_bus.valid && req_bus.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_bus.ready;

   assign full      = LW'(count_ff) >= limit_ff;
   assign remove_ok = LW'(pos_ff) < LW'(count_ff);
   assign idx_plus1 = {1'b0, idx_ff} + (CW+1)'(1);
   assign idx_plus2 = {1'b0, idx_ff} + (CW+1)'(2);
   assign more_after_rd    = idx_plus1 < {1'b0, count_ff};
   assign more_after_shift = idx_plus2 < {1'b0, count_ff};

   assign slot_count = wrap_add(front_ff, count_ff);
   assign slot_last  = wrap_add(front_ff, CW'(count_ff - 1'b1));
   assign slot_pos   = wrap_add(front_ff, CW'(pos_ff));
   assign slot_idx   = wrap_add(front_ff, idx_ff);
   assign slot_idx1  = wrap_add(front_ff, CW'(idx_plus1));
   assign slot_idx2  = wrap_add(front_ff, CW'(idx_plus2));
   assign front_dec  = wrap_add(front_ff, CW'(MAX_ENTRIES - 1));
   assign front_inc  = wrap_add(front_ff, CW'(1));

   // limit write: zero taken as one, above the store depth taken as the depth
   always_comb begin
      limit_clamp = LW'(csr_wr_data);
      if (csr_wr_data == '0) begin
         limit_clamp = LW'(1);
      end else if (int'(csr_wr_data) > MAX_ENTRIES) begin
         limit_clamp = LW'(MAX_ENTRIES);
      end
   end

   always_comb begin
      limit_in = limit_ff;
      if (csr_wr_en && (count_ff == '0)) begin
         limit_in = limit_clamp;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_PUSH_BACK,
               OP_PUSH_FRONT: state_in = full ? S_EVICT_RD : S_RESULT;
               OP_REMOVE:     state_in = remove_ok ? S_REMOVE_RD : S_RESULT;
               default:       state_in = S_RESULT;
            endcase
         end
         S_EVICT_RD:  state_in = S_RESULT;
         S_REMOVE_RD: state_in = more_after_rd ? S_SHIFT : S_RESULT;
         S_SHIFT:     state_in = more_after_shift ? S_SHIFT : S_RESULT;
         S_RESULT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      req_bus.ready  = 1'b0;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = slot_count;
      mem_raddr      = front_ff;
      mem_wdata      = word_ff;
      count_in       = count_ff;
      front_in       = front_ff;
      idx_in         = idx_ff;
      op_in          = op_ff;
      word_in        = word_ff;
      pos_in         = pos_ff;
      res_value_in   = res_value_ff;
      res_status_in  = res_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;

      case (state_ff)
         S_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_accept) begin
               op_in   = req_bus.payload.op;
               word_in = DATA_WIDTH'(req_bus.payload.value);
               pos_in  = req_bus.payload.position;
            end
         end
         S_EXEC: begin
            res_value_in  = '0;
            res_status_in = STATUS_OK;
            case (op_ff)
               OP_PUSH_BACK: begin
                  if (full) begin
                     mem_re    = 1'b1;
                     mem_raddr = front_ff;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = slot_count;
                     count_in  = CW'(count_ff + 1'b1);
                  end
               end
               OP_PUSH_FRONT: begin
                  if (full) begin
                     mem_re    = 1'b1;
                     mem_raddr = slot_last;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = front_dec;
                     front_in  = front_dec;
                     count_in  = CW'(count_ff + 1'b1);
                  end
               end
               OP_REMOVE: begin
                  if (remove_ok) begin
                     mem_re    = 1'b1;
                     mem_raddr = slot_pos;
                     idx_in    = CW'(pos_ff);
                  end else begin
                     res_status_in = STATUS_BAD_REMOVE;
                  end
               end
               default: res_status_in = STATUS_BAD_REMOVE;
            endcase
         end
         S_EVICT_RD: begin
            // evicted word was read last cycle, so the write is safe even when it lands on the same slot
            res_value_in = mem_rdata_ff;
            mem_we       = 1'b1;
            if (op_ff == OP_PUSH_BACK) begin
               mem_waddr     = slot_count;
               front_in      = front_inc;
               res_status_in = STATUS_EVICT_FRONT;
            end else begin
               mem_waddr     = front_dec;
               front_in      = front_dec;
               res_status_in = STATUS_EVICT_BACK;
            end
         end
         S_REMOVE_RD: begin
            res_value_in = mem_rdata_ff;
            if (more_after_rd) begin
               mem_re    = 1'b1;
               mem_raddr = slot_idx1;
            end else begin
               count_in = CW'(count_ff - 1'b1);
            end
         end
         S_SHIFT: begin
            // write back the word read last cycle one slot closer to the front
            mem_we    = 1'b1;
            mem_waddr = slot_idx;
            mem_wdata = mem_rdata_ff;
            idx_in    = CW'(idx_plus1);
            if (more_after_shift) begin
               mem_re    = 1'b1;
               mem_raddr = slot_idx2;
            end else begin
               count_in = CW'(count_ff - 1'b1);
            end
         end
         S_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.removed_value = VALUE_WIDTH'(res_value_ff);
               rsp_payload_in.status        = res_status_ff;
               rsp_payload_in.entry_count   = COUNT_WIDTH'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= store_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         front_ff     <= '0;
         limit_ff     <= LW'(MAX_ENTRIES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         front_ff     <= front_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      op_ff          <= op_in;
      word_ff        <= word_in;
      pos_ff         <= pos_in;
      res_value_ff   <= res_value_in;
      res_status_ff  <= res_status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

// ----- tb/bdq_outcome_checker.sv -----
// checker for the bounded deque: tracks the queue contents, predicts each result and compares
module bdq_outcome_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  bdq_pkg::req_payload_type          req_item,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  bdq_pkg::rsp_payload_type          rsp_item,
   input  logic                              csr_wr_en,
   input  logic [bdq_pkg::LIMIT_WIDTH-1:0]   csr_wr_data,
   output int                                mismatch_count,
   output int                                outstanding,
   output int                                held_entries
);
   timeunit 1ns;
   timeprecision 1ps;
   import bdq_pkg::*;

   localparam int MAX_MISMATCH_REPORTS = 10;

   logic [VALUE_WIDTH-1:0] slot_word [DEF_MAX_ENTRIES];
   int                     front_idx;
   int                     count_held;
   int                     limit_now;
   int                     errors;
   rsp_payload_type        predicted_outcomes [$];

   function automatic int slot_of(int offset);
      return (front_idx + offset) % DEF_MAX_ENTRIES;
   endfunction

   function automatic void take_limit(logic [LIMIT_WIDTH-1:0] raw);
      int v;
      // the limit only moves while nothing is held
      if (count_held != 0) return;
      v = int'(raw);
      if (v == 0) v = 1;
      if (v > DEF_MAX_ENTRIES) v = DEF_MAX_ENTRIES;
      limit_now = v;
   endfunction

   function automatic rsp_payload_type apply_transaction(req_payload_type item);
      rsp_payload_type res;
      logic            full;
      int              i;
      res.removed_value = '0;
      res.status        = STATUS_OK;
      full = (count_held >= limit_now);
      case (item.op)
         OP_PUSH_BACK: begin
            if (full && count_held > 0) begin
               // when full, the old front is evicted and the new word is written behind the back
               res.removed_value = slot_word[front_idx];
               slot_word[slot_of(count_held)] = item.value;
               front_idx = slot_of(1);
               res.status = STATUS_EVICT_FRONT;
            end else begin
               slot_word[slot_of(count_held)] = item.value;
               count_held++;
            end
         end
         OP_PUSH_FRONT: begin
            if (full && count_held > 0) begin
               res.removed_value = slot_word[slot_of(count_held - 1)];
               res.status = STATUS_EVICT_BACK;
            end else begin
               count_held++;
            end
            front_idx = slot_of(DEF_MAX_ENTRIES - 1);
            slot_word[front_idx] = item.value;
         end
         OP_REMOVE: begin
            if (int'(item.position) < count_held) begin
               res.removed_value = slot_word[slot_of(int'(item.position))];
               for (i = int'(item.position); i + 1 < count_held; i++)
                  slot_word[slot_of(i)] = slot_word[slot_of(i + 1)];
               count_held--;
            end else begin
               res.status = STATUS_BAD_REMOVE;
            end
         end
         default: res.status = STATUS_BAD_REMOVE;
      endcase
      res.entry_count = COUNT_WIDTH'(count_held);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type head;
      if (reset) begin
         front_idx  = 0;
         count_held = 0;
         limit_now  = DEF_MAX_ENTRIES;
         errors     = 0;
         predicted_outcomes.delete();
      end else begin
         if (csr_wr_en) take_limit(csr_wr_data);
         if (req_valid && req_ready) predicted_outcomes.push_back(apply_transaction(req_item));
         if (rsp_valid && rsp_ready) begin
            if (predicted_outcomes.size() == 0) begin
               errors++;
               if (errors <= MAX_MISMATCH_REPORTS)
                  $display("%0t: result with no transaction pending: removed=%h status=%0d count=%0d",
                           $realtime, rsp_item.removed_value, rsp_item.status,
                           rsp_item.entry_count);
            end else begin
               head = predicted_outcomes.pop_front();
               if (head.removed_value != rsp_item.removed_value ||
                   head.status != rsp_item.status ||
                   head.entry_count != rsp_item.entry_count) begin
                  errors++;
                  if (errors <= MAX_MISMATCH_REPORTS)
                     $display("%0t: mismatch: got removed=%h status=%0d count=%0d, predicted removed=%h status=%0d count=%0d",
                              $realtime, rsp_item.removed_value, rsp_item.status,
                              rsp_item.entry_count, head.removed_value, head.status,
                              head.entry_count);
               end
            end
         end
      end
      mismatch_count <= errors;
      outstanding    <= predicted_outcomes.size();
      held_entries   <= count_held;
   end

endmodule

// ----- tb/bounded_deque_with_eviction_top_tb.sv -----
// testbench top for the bounded deque with eviction: clock, reset, stimulus and verdict
module bounded_deque_with_eviction_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bdq_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 120;
   localparam int SETTLE_CYCLES  = 30;
   localparam int PHASE_ITEMS    = 34;
   localparam int PHASE_COUNT    = 10;
   localparam logic [OP_WIDTH-1:0] OP_UNDEFINED = 2'd3;
   localparam int PHASE_LIMIT [PHASE_COUNT] = '{16, 1, 3, 31, 7, 0, 16, 2, 17, 12};

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [LIMIT_WIDTH-1:0] csr_wr_data;

   int mismatch_count;
   int outstanding;
   int held_entries;

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int shape_limit     = DEF_MAX_ENTRIES;
   bit holdoff_req     = 1'b0;

   bdq_stream_if #(.payload_type(req_payload_type)) req_bus ();
   bdq_stream_if #(.payload_type(rsp_payload_type)) rsp_bus ();

   bounded_deque_with_eviction_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bdq_outcome_checker outcome_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_item       (req_bus.payload),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_item       (rsp_bus.payload),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .held_entries   (held_entries)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int k;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_req) begin
            holdoff_req = 1'b0;
            for (k = 0; k < HOLDOFF_CYCLES; k++) begin
               rsp_bus.ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      int stall_run;
      stall_run = 0;
      while (stall_run < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_run = 0;
         else
            stall_run++;
      end
      $display("bounded_deque_with_eviction_top verification failed");
      $finish;
   end

   function automatic req_payload_type build_item(logic [OP_WIDTH-1:0] op,
                                                  logic [VALUE_WIDTH-1:0] value,
                                                  logic [POSITION_WIDTH-1:0] position);
      req_payload_type item;
      item.op       = op;
      item.value    = value;
      item.position = position;
      return item;
   endfunction

   function automatic req_payload_type random_item();
      int                      roll;
      int                      pos;
      logic [OP_WIDTH-1:0]     op;
      logic [VALUE_WIDTH-1:0]  value;
      roll = $urandom_range(99);
      if (roll < 40)      op = OP_PUSH_BACK;
      else if (roll < 65) op = OP_PUSH_FRONT;
      else if (roll < 95) op = OP_REMOVE;
      else                op = OP_UNDEFINED;
      roll = $urandom_range(99);
      if (roll < 10)      value = '0;
      else if (roll < 20) value = '1;
      else                value = $urandom;
      // removes mostly aim at positions from zero to the current limit, so many land on real entries
      if (op == OP_REMOVE && $urandom_range(99) < 80) begin
         pos = $urandom_range(0, shape_limit);
         if (pos > DEF_MAX_ENTRIES - 1) pos = DEF_MAX_ENTRIES - 1;
      end else begin
         pos = $urandom_range(0, DEF_MAX_ENTRIES - 1);
      end
      return build_item(op, value, POSITION_WIDTH'(pos));
   endfunction

   task automatic offer_request(req_payload_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= item;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_WIDTH-1:0] raw);
      int v;
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= raw;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      if (held_entries == 0) begin
         v = int'(raw);
         if (v == 0) v = 1;
         if (v > DEF_MAX_ENTRIES) v = DEF_MAX_ENTRIES;
         shape_limit = v;
      end
   endtask

   task automatic empty_deque();
      int n;
      int i;
      wait_quiet();
      n = held_entries;
      for (i = 0; i < n; i++)
         offer_request(build_item(OP_REMOVE, $urandom,
                                  POSITION_WIDTH'($urandom_range(0, n - 1 - i))));
      wait_quiet();
   endtask

   initial begin
      int p;
      int n;
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty and undefined ops, extremes of the word, out of range positions
      offer_request(build_item(OP_REMOVE, 32'h0, 4'd0));
      offer_request(build_item(OP_UNDEFINED, 32'hFFFF_FFFF, 4'd15));
      offer_request(build_item(OP_PUSH_BACK, 32'h0000_0000, 4'd0));
      offer_request(build_item(OP_PUSH_BACK, 32'hFFFF_FFFF, 4'd15));
      offer_request(build_item(OP_PUSH_FRONT, 32'hA5A5_A5A5, 4'd5));
      offer_request(build_item(OP_PUSH_FRONT, 32'h5A5A_5A5A, 4'd10));
      offer_request(build_item(OP_REMOVE, 32'h0, 4'd15));
      offer_request(build_item(OP_REMOVE, 32'h0, 4'd3));
      offer_request(build_item(OP_REMOVE, 32'hFFFF_FFFF, 4'd0));
      offer_request(build_item(OP_UNDEFINED, 32'h1234_5678, 4'd0));
      // limit write while entries are held must be ignored
      write_limit(5'd4);
      offer_request(build_item(OP_REMOVE, 32'h0, 4'd1));
      offer_request(build_item(OP_REMOVE, 32'h0, 4'd0));
      // zero limit acts as one
      write_limit(5'd0);
      offer_request(build_item(OP_PUSH_BACK, 32'h1111_1111, 4'd0));
      offer_request(build_item(OP_PUSH_BACK, 32'h2222_2222, 4'd0));
      offer_request(build_item(OP_PUSH_FRONT, 32'h3333_3333, 4'd0));
      offer_request(build_item(OP_REMOVE, 32'h0, 4'd1));
      offer_request(build_item(OP_REMOVE, 32'h0, 4'd0));
      write_limit(5'd2);
      offer_request(build_item(OP_PUSH_BACK, 32'h8000_0001, 4'd0));
      offer_request(build_item(OP_PUSH_BACK, 32'h7FFF_FFFE, 4'd0));
      offer_request(build_item(OP_PUSH_BACK, 32'hDEAD_BEEF, 4'd0));
      offer_request(build_item(OP_PUSH_FRONT, 32'hCAFE_F00D, 4'd0));
      offer_request(build_item(OP_REMOVE, 32'h0, 4'd1));
      offer_request(build_item(OP_REMOVE, 32'h0, 4'd0));
      empty_deque();

      for (p = 0; p < PHASE_COUNT; p++) begin
         case (p % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 59; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 59; end
            default: begin sender_idle_pct = 33; stall_pct = 33; end
         endcase
         write_limit(LIMIT_WIDTH'(PHASE_LIMIT[p]));
         // one phase starves the result side so the input backs up
         if (p == 4) holdoff_req = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++)
            offer_request(random_item());
         empty_deque();
      end

      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("bounded_deque_with_eviction_top verification clean");
      else
         $display("bounded_deque_with_eviction_top verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/bdq_pkg.sv
src/bdq_stream_if.sv
src/bounded_deque_with_eviction_top.sv
tb/bdq_outcome_checker.sv
tb/bounded_deque_with_eviction_top_tb.sv
